// ===== hw/rtl/dns_response_ipv4_extractor_macros.svh =====
// ----------------------------------------------------------------------------
// dns_response_ipv4_extractor_macros.svh
// Assertion helpers shared by the extractor RTL.
// ----------------------------------------------------------------------------
`ifndef DNS_RESPONSE_IPV4_EXTRACTOR_MACROS_SVH
`define DNS_RESPONSE_IPV4_EXTRACTOR_MACROS_SVH

// same-cycle implication, sampled on clock, off during reset
`define DNSX_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define DNSX_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/dnsx_pkg.sv =====
// ----------------------------------------------------------------------------
// dnsx_pkg
// Types and constants for the DNS response IPv4 extractor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dnsx_pkg;

   // header layout
   localparam int unsigned HEADER_LEN    = 12;
   localparam logic [3:0]  OFS_ID_HI     = 4'd0;
   localparam logic [3:0]  OFS_ID_LO     = 4'd1;
   localparam logic [3:0]  OFS_FLAGS_LO  = 4'd3;
   localparam logic [3:0]  OFS_ANCOUNT_HI = 4'd6;
   localparam logic [3:0]  OFS_ANCOUNT_LO = 4'd7;
   localparam logic [3:0]  OFS_HDR_END   = 4'(HEADER_LEN - 1);

   localparam logic [15:0] TXN_ID_RESET  = 16'h1234;
   localparam logic [7:0]  RCODE_MASK    = 8'h0F;
   localparam logic [7:0]  PTR_MASK      = 8'hC0;
   localparam logic [15:0] TYPE_A        = 16'h0001;
   localparam logic [15:0] A_DATA_LEN    = 16'd4;
   localparam logic [15:0] QTAIL_LEN     = 16'd4;

   // positions inside the ten fixed bytes of an answer record
   localparam logic [15:0] FIX_TYPE_HI   = 16'd0;
   localparam logic [15:0] FIX_TYPE_LO   = 16'd1;
   localparam logic [15:0] FIX_LEN_HI    = 16'd8;
   localparam logic [15:0] FIX_LEN_LO    = 16'd9;

   localparam logic [1:0]  VERDICT_IGNORED = 2'd0;
   localparam logic [1:0]  VERDICT_ERROR   = 2'd1;
   localparam logic [1:0]  VERDICT_SUCCESS = 2'd2;

   typedef enum logic [9:0] {
      PH_HDR    = 10'b00_0000_0001,
      PH_QNAME  = 10'b00_0000_0010,
      PH_QTAIL  = 10'b00_0000_0100,
      PH_ANAME  = 10'b00_0000_1000,
      PH_ALABEL = 10'b00_0001_0000,
      PH_APTR   = 10'b00_0010_0000,
      PH_FIXED  = 10'b00_0100_0000,
      PH_RDATA  = 10'b00_1000_0000,
      PH_ADDR   = 10'b01_0000_0000,
      PH_DONE   = 10'b10_0000_0000
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]  verdict;
      logic [31:0] resolved_address;
   } rsp_payload_type;

endpackage

// ===== hw/rtl/dns_response_ipv4_extractor.sv =====
// ----------------------------------------------------------------------------
// dns_response_ipv4_extractor
// Byte-serial DNS response parser that reports the first IPv4 A record.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one payload byte per item, last_byte set on the final byte.
//   rsp_*  : one verdict item per packet (0 ignored, 1 error, 2 success),
//            with the address on success and zero otherwise.
//   csr_*  : write of the expected transaction id; always ready. Write it
//            only while no packet is in flight.
// Throughput is one byte per cycle while req_stall is low: each byte is
// registered, then a single pass of phase/counter logic updates the parse state.
// The verdict is loaded into the result register when the last byte leaves
// the input register, and is shown on rsp_valid from then on.
// When rsp_stall holds a result, non-final bytes keep flowing; only a
// following last byte waits in the input register, so req_stall rises
// only then.
// Reset (synchronous) empties both registers, rearms the parser at the
// header and restores the transaction id to 0x1234.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "dns_response_ipv4_extractor_macros.svh"

module dns_response_ipv4_extractor
   import dnsx_pkg::*;
(
   input  logic            clock,
   input  logic            reset,

   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,

   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload,

   input  logic            csr_valid,
   output logic            csr_ready,
   input  logic [15:0]     csr_wdata
);

   // configuration
   logic [15:0]     tid_ff;

   // input register
   logic            s1_valid_ff, s1_valid_in;
   req_payload_type s1_item_ff;

   // parse state
   phase_type       phase_ff, phase_in;
   logic [3:0]      offset_ff, offset_in;
   logic [7:0]      id_hi_ff, id_hi_in;
   logic [15:0]     answers_ff, answers_in;
   logic [15:0]     skip_ff, skip_in;
   logic [15:0]     rtype_ff, rtype_in;
   logic [7:0]      len_hi_ff, len_hi_in;
   logic [31:0]     accum_ff, accum_in;
   logic [1:0]      pending_ff, pending_in;

   // result register
   logic            out_valid_ff, out_valid_in;
   rsp_payload_type out_item_ff, out_item_in;

   logic            advance;
   logic            accept;
   logic            load_out;
   logic [7:0]      b;
   logic [15:0]     skip_dec;
   logic [15:0]     ans_dec;
   logic [15:0]     rec_len;

   assign b         = s1_item_ff.data_byte;
   assign advance   = s1_valid_ff & ~(s1_item_ff.last_byte & out_valid_ff & rsp_stall);
   assign load_out  = advance & s1_item_ff.last_byte;
   assign req_stall = s1_valid_ff & ~advance;
   assign accept    = req_valid & ~req_stall;

   assign s1_valid_in  = accept | (s1_valid_ff & ~advance);
   assign out_valid_in = load_out | (out_valid_ff & rsp_stall);

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_item_ff;
   assign csr_ready   = 1'b1;

   assign skip_dec = skip_ff - 16'd1;
   assign ans_dec  = answers_ff - 16'd1;
   assign rec_len  = {len_hi_ff, b};

   always_comb begin
      phase_in   = phase_ff;
      offset_in  = offset_ff;
      id_hi_in   = id_hi_ff;
      answers_in = answers_ff;
      skip_in    = skip_ff;
      rtype_in   = rtype_ff;
      len_hi_in  = len_hi_ff;
      accum_in   = accum_ff;
      pending_in = pending_ff;

      case (phase_ff)
         PH_HDR: begin
            offset_in = offset_ff + 4'd1;
            if (offset_ff == OFS_ID_HI) begin
               id_hi_in = b;
            end else if (offset_ff == OFS_ID_LO) begin
               if ({id_hi_ff, b} != tid_ff) begin
                  pending_in = VERDICT_IGNORED;
                  phase_in   = PH_DONE;
               end
            end else if (offset_ff == OFS_FLAGS_LO) begin
               if ((b & RCODE_MASK) != 8'h00) begin
                  pending_in = VERDICT_ERROR;
               end
            end else if (offset_ff == OFS_ANCOUNT_HI) begin
               answers_in = {b, 8'h00};
            end else if (offset_ff == OFS_ANCOUNT_LO) begin
               answers_in = {answers_ff[15:8], b};
            end else if (offset_ff == OFS_HDR_END) begin
               if (pending_ff == VERDICT_ERROR || answers_ff == 16'd0) begin
                  pending_in = VERDICT_ERROR;
                  phase_in   = PH_DONE;
               end else begin
                  phase_in = PH_QNAME;
               end
            end
         end
         PH_QNAME: begin
            if (b == 8'h00) begin
               skip_in  = QTAIL_LEN;
               phase_in = PH_QTAIL;
            end
         end
         PH_QTAIL, PH_ALABEL: begin
            skip_in = skip_dec;
            if (skip_dec == 16'd0) begin
               phase_in = PH_ANAME;
            end
         end
         PH_ANAME: begin
            if ((b & PTR_MASK) == PTR_MASK) begin
               phase_in = PH_APTR;
            end else if (b == 8'h00) begin
               skip_in  = 16'd0;
               phase_in = PH_FIXED;
            end else begin
               skip_in  = {8'h00, b};
               phase_in = PH_ALABEL;
            end
         end
         PH_APTR: begin
            skip_in  = 16'd0;
            phase_in = PH_FIXED;
         end
         PH_FIXED: begin
            skip_in = skip_ff + 16'd1;
            if (skip_ff == FIX_TYPE_HI) begin
               rtype_in = {b, 8'h00};
            end else if (skip_ff == FIX_TYPE_LO) begin
               rtype_in = {rtype_ff[15:8], b};
            end else if (skip_ff == FIX_LEN_HI) begin
               len_hi_in = b;
            end else if (skip_ff == FIX_LEN_LO) begin
               // record length completes on this byte
               if (rtype_ff == TYPE_A && rec_len == A_DATA_LEN) begin
                  skip_in  = A_DATA_LEN;
                  accum_in = 32'd0;
                  phase_in = PH_ADDR;
               end else if (rec_len == 16'd0) begin
                  answers_in = ans_dec;
                  if (ans_dec == 16'd0) begin
                     pending_in = VERDICT_ERROR;
                     phase_in   = PH_DONE;
                  end else begin
                     phase_in = PH_ANAME;
                  end
               end else begin
                  skip_in  = rec_len;
                  phase_in = PH_RDATA;
               end
            end
         end
         PH_RDATA: begin
            skip_in = skip_dec;
            if (skip_dec == 16'd0) begin
               answers_in = ans_dec;
               if (ans_dec == 16'd0) begin
                  pending_in = VERDICT_ERROR;
                  phase_in   = PH_DONE;
               end else begin
                  phase_in = PH_ANAME;
               end
            end
         end
         PH_ADDR: begin
            accum_in = {accum_ff[23:0], b};
            skip_in  = skip_dec;
            if (skip_dec == 16'd0) begin
               pending_in = VERDICT_SUCCESS;
               phase_in   = PH_DONE;
            end
         end
         PH_DONE: begin
            // drop trailing bytes until the end of the packet
         end
         default: begin
            phase_in = PH_HDR;
         end
      endcase

      // verdict comes from the state after this byte
      if (phase_in == PH_DONE) begin
         out_item_in.verdict = pending_in;
      end else begin
         out_item_in.verdict = VERDICT_IGNORED;
      end
      if (out_item_in.verdict == VERDICT_SUCCESS) begin
         out_item_in.resolved_address = accum_in;
      end else begin
         out_item_in.resolved_address = 32'd0;
      end

      // rearm for the next packet
      if (s1_item_ff.last_byte) begin
         phase_in   = PH_HDR;
         offset_in  = 4'd0;
         pending_in = VERDICT_IGNORED;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tid_ff       <= TXN_ID_RESET;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         phase_ff     <= PH_HDR;
         offset_ff    <= 4'd0;
         pending_ff   <= VERDICT_IGNORED;
      end else begin
         if (csr_valid & csr_ready) begin
            tid_ff <= csr_wdata;
         end
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            phase_ff   <= phase_in;
            offset_ff  <= offset_in;
            pending_ff <= pending_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_item_ff <= req_payload;
      end
      if (advance) begin
         id_hi_ff   <= id_hi_in;
         answers_ff <= answers_in;
         skip_ff    <= skip_in;
         rtype_ff   <= rtype_in;
         len_hi_ff  <= len_hi_in;
         accum_ff   <= accum_in;
      end
      if (load_out) begin
         out_item_ff <= out_item_in;
      end
   end

   `DNSX_ASSERT_IMP(a_stall_only_on_blocked_last,
      req_stall, s1_valid_ff && s1_item_ff.last_byte && out_valid_ff && rsp_stall,
      "input stalled without a blocked final byte")

   `DNSX_ASSERT_NXT(a_rearm_after_last,
      load_out, phase_ff == PH_HDR && offset_ff == 4'd0 && pending_ff == VERDICT_IGNORED,
      "parser not rearmed after final byte")

   `DNSX_ASSERT_IMP(a_address_zero_unless_success,
      out_valid_ff && out_item_ff.verdict != VERDICT_SUCCESS,
      out_item_ff.resolved_address == 32'd0,
      "address nonzero on a non-success verdict")

   `DNSX_ASSERT_IMP(a_header_offset_range,
      phase_ff == PH_HDR, offset_ff <= OFS_HDR_END,
      "header offset past end of header")

   `DNSX_ASSERT_NXT(a_result_held_for_stall,
      out_valid_ff && rsp_stall, out_valid_ff && $stable(out_item_ff),
      "pending verdict lost while receiver stalled")

endmodule
